// ----- hdl/btsl_pkg.sv -----
// btsl_pkg: parse phases, result kinds and the result record of the boot table loader
// no dependencies; imported by btsl_parse and boot_table_section_loader_unit
`default_nettype none

package btsl_pkg;

	typedef enum logic [2:0] {
		PH_TOTAL,
		PH_COUNT,
		PH_CSIZE,
		PH_CENTRY,
		PH_SLEN,
		PH_SADDR,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_MEM,
		KIND_ENTRY,
		KIND_END,
		KIND_ERR
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [31:0] address;
		logic [7:0]  write_byte;
		logic [2:0]  core_index;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/btsl_parse.sv -----
// btsl_parse: boot table parse state and the per-byte step logic
// depends on btsl_pkg; instantiated by boot_table_section_loader_unit
`default_nettype none

module btsl_parse
	import btsl_pkg::*;
#(
	parameter int MAX_CORES = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic [7:0] step_byte,
	input  wire logic       big_endian,
	output result_t         res,
	output logic            parse_done
);

	phase_t      phase_q, phase_n;
	logic [1:0]  fbc_q, fbc_n;
	logic [31:0] word_q, word_n;
	logic [31:0] word_full;
	logic [31:0] len_m1_q, len_m1_n;
	logic [31:0] sect_addr_q, sect_addr_n;
	logic [31:0] offset_q, offset_n;
	logic [3:0]  core_total_q, core_total_n;
	logic [3:0]  core_pos_q, core_pos_n;
	logic [3:0]  core_pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TOTAL;
			fbc_q        <= '0;
			word_q       <= '0;
			len_m1_q     <= '0;
			sect_addr_q  <= '0;
			offset_q     <= '0;
			core_total_q <= '0;
			core_pos_q   <= '0;
		end else begin
			phase_q      <= phase_n;
			fbc_q        <= fbc_n;
			word_q       <= word_n;
			len_m1_q     <= len_m1_n;
			sect_addr_q  <= sect_addr_n;
			offset_q     <= offset_n;
			core_total_q <= core_total_n;
			core_pos_q   <= core_pos_n;
		end
	end

	assign word_full = big_endian ? {word_q[23:0], step_byte}
	                              : (word_q | (32'(step_byte) << {fbc_q, 3'b000}));
	assign core_pos_inc = core_pos_q + 4'd1;
	assign parse_done   = (phase_q == PH_DONE);

	always_comb begin
		phase_n      = phase_q;
		fbc_n        = fbc_q;
		word_n       = word_q;
		len_m1_n     = len_m1_q;
		sect_addr_n  = sect_addr_q;
		offset_n     = offset_q;
		core_total_n = core_total_q;
		core_pos_n   = core_pos_q;
		res          = '0;
		res.kind     = KIND_MEM;
		if (step_en) begin
			unique case (phase_q)
				PH_DONE: begin
				end
				PH_DATA: begin
					if (offset_q <= len_m1_q) begin
						res.valid      = 1'b1;
						res.kind       = KIND_MEM;
						res.address    = sect_addr_q + offset_q;
						res.write_byte = step_byte;
					end
					if (offset_q[1:0] == 2'b11 && offset_q >= len_m1_q) begin
						phase_n  = PH_SLEN;
						offset_n = '0;
					end else begin
						offset_n = offset_q + 32'd1;
					end
				end
				PH_TOTAL, PH_COUNT, PH_CSIZE, PH_CENTRY, PH_SLEN, PH_SADDR: begin
					if (fbc_q != 2'd3) begin
						word_n = word_full;
						fbc_n  = fbc_q + 2'd1;
					end else begin
						word_n = '0;
						fbc_n  = '0;
						case (phase_q)
							PH_TOTAL: phase_n = PH_COUNT;
							PH_COUNT: begin
								if (word_full > 32'(MAX_CORES)) begin
									res.valid = 1'b1;
									res.kind  = KIND_ERR;
									phase_n   = PH_DONE;
								end else begin
									core_total_n = word_full[3:0];
									core_pos_n   = '0;
									phase_n      = (word_full != '0) ? PH_CSIZE : PH_SLEN;
								end
							end
							PH_CSIZE: phase_n = PH_CENTRY;
							PH_CENTRY: begin
								res.valid      = 1'b1;
								res.kind       = KIND_ENTRY;
								res.address    = word_full;
								res.core_index = core_pos_q[2:0];
								core_pos_n     = core_pos_inc;
								phase_n        = (core_pos_inc < core_total_q) ? PH_CSIZE
								                                               : PH_SLEN;
							end
							PH_SLEN: begin
								if (word_full == '0) begin
									res.valid = 1'b1;
									res.kind  = KIND_END;
									phase_n   = PH_DONE;
								end else begin
									len_m1_n = word_full - 32'd1;
									phase_n  = PH_SADDR;
								end
							end
							PH_SADDR: begin
								sect_addr_n = word_full;
								offset_n    = '0;
								phase_n     = PH_DATA;
							end
							default: phase_n = PH_DONE;
						endcase
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/boot_table_section_loader_unit.sv -----
// boot_table_section_loader_unit: top level, input register, parser and result register
// depends on btsl_pkg and btsl_parse
// a byte passes from the input register through the parse step into the result register
// throughput: one byte per cycle, set by the parse step between the input and result registers;
// a result held by out_stall holds the input register and then stalls the next byte
// reset: asynchronous, clears the parse state, both pipeline valid flags and byte order
`default_nettype none

module boot_table_section_loader_unit
	import btsl_pkg::*;
#(
	parameter int MAX_CORES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        word_byte_order,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [31:0]      address,
	output logic [7:0]       write_byte,
	output logic [2:0]       core_index
);

	logic       order_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step_en;
	logic       parse_done;
	result_t    res;
	result_t    out_q;
	logic       out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_valid) begin
			order_q <= word_byte_order;
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	btsl_parse #(
		.MAX_CORES(MAX_CORES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.step_byte  (byte_s1),
		.big_endian (order_q),
		.res        (res),
		.parse_done (parse_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_en && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_en && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_q.kind;
	assign address    = out_q.address;
	assign write_byte = out_q.write_byte;
	assign core_index = out_q.core_index;

	// a stalled input register only while a result is held back
	a_stall_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	// end of table or error moves the parse to its final phase
	a_done_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.valid && (res.kind == KIND_END || res.kind == KIND_ERR))
		|=> parse_done)
		else $error("final result without parse done");

	// nothing leaves once the parse is finished
	a_silent_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(parse_done && step_en) |-> !res.valid)
		else $error("result after parse done");

	// data byte and core index only on their own kinds
	a_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.kind == KIND_MEM || out_q.write_byte == '0) &&
		                 (out_q.kind == KIND_ENTRY || out_q.core_index == '0)))
		else $error("stray payload field");

endmodule

`default_nettype wire
